[rtl/ps2_set2_key_event_decoder_macros.svh]
// Assertion helpers for the key event decoder.
`ifndef PS2_SET2_KEY_EVENT_DECODER_MACROS_SVH
`define PS2_SET2_KEY_EVENT_DECODER_MACROS_SVH

`define PKD_ASSERT_IMPL(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("assertion failed");

`define PKD_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("assertion failed");

`endif

[rtl/pkd_pkg.sv]
`default_nettype none
package pkd_pkg;

  localparam int unsigned RingDepthDefault = 32;

  typedef enum logic [1:0] {
    ACT_SCAN  = 2'd0,
    ACT_POP   = 2'd1,
    ACT_PRESS = 2'd2,
    ACT_QUERY = 2'd3
  } action_e;

  localparam logic [7:0] ScExt   = 8'hE0;
  localparam logic [7:0] ScBreak = 8'hF0;
  localparam logic [7:0] ScLsh   = 8'h12;
  localparam logic [7:0] ScRsh   = 8'h59;
  localparam logic [7:0] ScCtrl  = 8'h14;
  localparam logic [7:0] ScAlt   = 8'h11;
  localparam logic [7:0] ScUp    = 8'h75;
  localparam logic [7:0] ScDown  = 8'h72;
  localparam logic [7:0] ScLeft  = 8'h6B;
  localparam logic [7:0] ScRight = 8'h74;

  localparam logic [6:0] CodeUp    = 7'h01;
  localparam logic [6:0] CodeDown  = 7'h02;
  localparam logic [6:0] CodeLeft  = 7'h03;
  localparam logic [6:0] CodeRight = 7'h04;
  localparam logic [6:0] CodeShift = 7'h05;
  localparam logic [6:0] CodeCtrl  = 7'h06;
  localparam logic [6:0] CodeAlt   = 7'h07;
  localparam logic [6:0] CodeCtrlQ = 7'h11;

  typedef struct packed {
    action_e    action;
    logic [6:0] code;
    logic       rel;
    logic       abort;
  } cmd_t;

  function automatic logic [6:0] rom_lookup(input logic [6:0] sc, input logic shifted);
    logic [6:0] p;
    logic [6:0] s;
    p = 7'h00;
    s = 7'h00;
    case (sc)
      7'h0D: begin p = 7'h09; s = 7'h09; end
      7'h0E: begin p = 7'h60; s = 7'h7E; end
      7'h15: begin p = 7'h71; s = 7'h51; end
      7'h16: begin p = 7'h31; s = 7'h21; end
      7'h1A: begin p = 7'h7A; s = 7'h5A; end
      7'h1B: begin p = 7'h73; s = 7'h53; end
      7'h1C: begin p = 7'h61; s = 7'h41; end
      7'h1D: begin p = 7'h77; s = 7'h57; end
      7'h1E: begin p = 7'h32; s = 7'h40; end
      7'h21: begin p = 7'h63; s = 7'h43; end
      7'h22: begin p = 7'h78; s = 7'h58; end
      7'h23: begin p = 7'h64; s = 7'h44; end
      7'h24: begin p = 7'h65; s = 7'h45; end
      7'h25: begin p = 7'h34; s = 7'h24; end
      7'h26: begin p = 7'h33; s = 7'h23; end
      7'h29: begin p = 7'h20; s = 7'h20; end
      7'h2A: begin p = 7'h76; s = 7'h56; end
      7'h2B: begin p = 7'h66; s = 7'h46; end
      7'h2C: begin p = 7'h74; s = 7'h54; end
      7'h2D: begin p = 7'h72; s = 7'h52; end
      7'h2E: begin p = 7'h35; s = 7'h25; end
      7'h31: begin p = 7'h6E; s = 7'h4E; end
      7'h32: begin p = 7'h62; s = 7'h42; end
      7'h33: begin p = 7'h68; s = 7'h48; end
      7'h34: begin p = 7'h67; s = 7'h47; end
      7'h35: begin p = 7'h79; s = 7'h59; end
      7'h36: begin p = 7'h36; s = 7'h5E; end
      7'h3A: begin p = 7'h6D; s = 7'h4D; end
      7'h3B: begin p = 7'h6A; s = 7'h4A; end
      7'h3C: begin p = 7'h75; s = 7'h55; end
      7'h3D: begin p = 7'h37; s = 7'h26; end
      7'h3E: begin p = 7'h38; s = 7'h2A; end
      7'h41: begin p = 7'h2C; s = 7'h3C; end
      7'h42: begin p = 7'h6B; s = 7'h4B; end
      7'h43: begin p = 7'h69; s = 7'h49; end
      7'h44: begin p = 7'h6F; s = 7'h4F; end
      7'h45: begin p = 7'h30; s = 7'h29; end
      7'h46: begin p = 7'h39; s = 7'h28; end
      7'h49: begin p = 7'h2E; s = 7'h3E; end
      7'h4A: begin p = 7'h2F; s = 7'h3F; end
      7'h4B: begin p = 7'h6C; s = 7'h4C; end
      7'h4C: begin p = 7'h3B; s = 7'h3A; end
      7'h4D: begin p = 7'h70; s = 7'h50; end
      7'h4E: begin p = 7'h2D; s = 7'h5F; end
      7'h52: begin p = 7'h27; s = 7'h22; end
      7'h54: begin p = 7'h5B; s = 7'h7B; end
      7'h55: begin p = 7'h3D; s = 7'h2B; end
      7'h5A: begin p = 7'h0A; s = 7'h0A; end
      7'h5B: begin p = 7'h5D; s = 7'h7D; end
      7'h5D: begin p = 7'h5C; s = 7'h7C; end
      7'h66: begin p = 7'h08; s = 7'h08; end
      7'h69: begin p = 7'h31; s = 7'h31; end
      7'h6B: begin p = 7'h34; s = 7'h34; end
      7'h6C: begin p = 7'h37; s = 7'h37; end
      7'h70: begin p = 7'h30; s = 7'h30; end
      7'h71: begin p = 7'h2E; s = 7'h2E; end
      7'h72: begin p = 7'h32; s = 7'h32; end
      7'h73: begin p = 7'h35; s = 7'h35; end
      7'h74: begin p = 7'h36; s = 7'h36; end
      7'h75: begin p = 7'h38; s = 7'h38; end
      7'h76: begin p = 7'h1B; s = 7'h1B; end
      7'h79: begin p = 7'h2B; s = 7'h2B; end
      7'h7A: begin p = 7'h33; s = 7'h33; end
      7'h7B: begin p = 7'h2D; s = 7'h2D; end
      7'h7C: begin p = 7'h2A; s = 7'h2A; end
      7'h7D: begin p = 7'h39; s = 7'h39; end
      default: begin p = 7'h00; s = 7'h00; end
    endcase
    return shifted ? s : p;
  endfunction

endpackage
`default_nettype wire

[rtl/pkd_ram.sv]
`default_nettype none
module pkd_ram #(
  parameter int unsigned Width = 8,
  parameter int unsigned Depth = 32
) (
  input  wire logic                     clk_i,
  input  wire logic                     we_i,
  input  wire logic [$clog2(Depth)-1:0] waddr_i,
  input  wire logic [Width-1:0]         wdata_i,
  input  wire logic [$clog2(Depth)-1:0] raddr_i,
  output logic      [Width-1:0]         rdata_o
);
  logic [Width-1:0] mem_q [Depth];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_o <= mem_q[raddr_i];
  end
endmodule
`default_nettype wire

[rtl/pkd_front.sv]
`default_nettype none
module pkd_front import pkd_pkg::*; (
  input  wire logic       clk_i,
  input  wire logic       rst_ni,
  input  wire logic       push,
  output logic            full,
  input  wire logic [1:0] action_i,
  input  wire logic [7:0] scan_byte_i,
  input  wire logic [6:0] key_i,
  output logic            cmd_valid_o,
  input  wire logic       cmd_ready_i,
  output cmd_t            cmd_o
);
  logic       shift_q, ctrl_q, brk_q, ext_q;
  logic       slot_q [2];
  cmd_t       buf_q [2];
  logic       wp_q, rp_q;
  action_e    act;
  logic [6:0] code;
  logic       abort_now;
  cmd_t       cmd;

  assign act = action_e'(action_i);
  assign full = slot_q[wp_q];
  assign cmd_valid_o = slot_q[rp_q];
  assign cmd_o = buf_q[rp_q];

  always_comb begin
    code = 7'h00;
    abort_now = 1'b0;
    if (ext_q) begin
      case (scan_byte_i)
        ScUp:    code = CodeUp;
        ScDown:  code = CodeDown;
        ScLeft:  code = CodeLeft;
        ScRight: code = CodeRight;
        ScAlt:   code = CodeAlt;
        ScCtrl:  code = CodeCtrl;
        default: code = 7'h00;
      endcase
    end else if (scan_byte_i == ScLsh || scan_byte_i == ScRsh) begin
      code = CodeShift;
    end else if (scan_byte_i == ScCtrl) begin
      code = CodeCtrl;
    end else if (scan_byte_i == ScAlt) begin
      code = CodeAlt;
    end else if (!scan_byte_i[7]) begin
      code = rom_lookup(scan_byte_i[6:0], shift_q);
      if (ctrl_q && (code == 7'h71 || code == 7'h51)) begin
        code = CodeCtrlQ;
        abort_now = !brk_q;
      end
    end
  end

  always_comb begin
    cmd.action = act;
    cmd.code = (act == ACT_QUERY) ? key_i : code;
    cmd.rel = brk_q;
    cmd.abort = 1'b0;
    case (act)
      ACT_SCAN: begin
        cmd.abort = abort_now;
        if (scan_byte_i == ScExt || scan_byte_i == ScBreak) begin
          cmd.code = 7'h00;
          cmd.abort = 1'b0;
        end
      end
      default: cmd.rel = 1'b0;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      shift_q <= 1'b0;
      ctrl_q <= 1'b0;
      brk_q <= 1'b0;
      ext_q <= 1'b0;
      wp_q <= 1'b0;
      rp_q <= 1'b0;
      slot_q[0] <= 1'b0;
      slot_q[1] <= 1'b0;
    end else begin
      if (cmd_valid_o && cmd_ready_i) begin
        slot_q[rp_q] <= 1'b0;
        rp_q <= ~rp_q;
      end
      if (push && !full) begin
        slot_q[wp_q] <= 1'b1;
        buf_q[wp_q] <= cmd;
        wp_q <= ~wp_q;
        if (act == ACT_SCAN) begin
          if (scan_byte_i == ScExt) begin
            ext_q <= 1'b1;
          end else if (scan_byte_i == ScBreak) begin
            brk_q <= 1'b1;
          end else begin
            brk_q <= 1'b0;
            ext_q <= 1'b0;
            if (!ext_q && (scan_byte_i == ScLsh || scan_byte_i == ScRsh)) begin
              shift_q <= !brk_q;
            end
            if (!ext_q && scan_byte_i == ScCtrl) begin
              ctrl_q <= !brk_q;
            end
          end
        end
      end
    end
  end
endmodule
`default_nettype wire

[rtl/pkd_back.sv]
`default_nettype none
module pkd_back import pkd_pkg::*; #(
  parameter int unsigned RingDepth = RingDepthDefault
) (
  input  wire logic  clk_i,
  input  wire logic  rst_ni,
  input  wire logic  cmd_valid_i,
  output logic       cmd_ready_o,
  input  wire cmd_t  cmd_i,
  output logic       empty,
  input  wire logic  pop,
  output logic       found_o,
  output logic [6:0] code_o,
  output logic       is_release_o,
  output logic       key_down_o,
  output logic       abort_request_o
);
  localparam int unsigned AW = (RingDepth > 1) ? $clog2(RingDepth) : 1;
  localparam logic [AW-1:0] Last = AW'(RingDepth - 1);
  localparam int unsigned KeyCount = 128;

  typedef enum logic [5:0] {
    ST_CLEAR = 6'b000001,
    ST_IDLE  = 6'b000010,
    ST_READ  = 6'b000100,
    ST_EVAL  = 6'b001000,
    ST_QRY   = 6'b010000,
    ST_OUT   = 6'b100000
  } state_e;

  state_e     state_q, state_d;
  logic [AW-1:0] wr_q, rd_q, wr_nxt, rd_nxt;
  cmd_t       cur_q;
  logic       scan_ev;
  logic       we;
  logic [7:0] rdata;
  logic [6:0] clr_q;
  logic       held_we, held_wdata, held_rdata;
  logic [6:0] held_waddr;
  logic       found_q;
  logic [6:0] code_q;
  logic       rel_q, down_q, abort_q;

  assign wr_nxt = (wr_q == Last) ? '0 : wr_q + 1'b1;
  assign rd_nxt = (rd_q == Last) ? '0 : rd_q + 1'b1;
  assign scan_ev = (state_q == ST_IDLE) && cmd_valid_i && cmd_i.action == ACT_SCAN
                   && cmd_i.code != 7'h00;
  assign we = scan_ev && wr_nxt != rd_q;

  pkd_ram #(.Width(8), .Depth(RingDepth)) u_ring (
    .clk_i  (clk_i),
    .we_i   (we),
    .waddr_i(wr_q),
    .wdata_i({cmd_i.rel, cmd_i.code}),
    .raddr_i(rd_q),
    .rdata_o(rdata)
  );

  assign held_we = (state_q == ST_CLEAR) || scan_ev;
  assign held_waddr = (state_q == ST_CLEAR) ? clr_q : cmd_i.code;
  assign held_wdata = (state_q == ST_CLEAR) ? 1'b0 : ~cmd_i.rel;

  pkd_ram #(.Width(1), .Depth(KeyCount)) u_held (
    .clk_i  (clk_i),
    .we_i   (held_we),
    .waddr_i(held_waddr),
    .wdata_i(held_wdata),
    .raddr_i(cmd_i.code),
    .rdata_o(held_rdata)
  );

  assign cmd_ready_o = (state_q == ST_IDLE);
  assign empty = (state_q != ST_OUT);
  assign found_o = found_q;
  assign code_o = code_q;
  assign is_release_o = rel_q;
  assign key_down_o = down_q;
  assign abort_request_o = abort_q;

  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_CLEAR: if (clr_q == 7'h7F) state_d = ST_IDLE;
      ST_IDLE: begin
        if (cmd_valid_i) begin
          if (cmd_i.action == ACT_POP || cmd_i.action == ACT_PRESS) begin
            state_d = ST_READ;
          end else if (cmd_i.action == ACT_QUERY) begin
            state_d = ST_QRY;
          end else begin
            state_d = ST_OUT;
          end
        end
      end
      ST_READ: state_d = (rd_q == wr_q) ? ST_OUT : ST_EVAL;
      ST_EVAL: begin
        if (cur_q.action == ACT_PRESS && rdata[7]) begin
          state_d = ST_READ;
        end else begin
          state_d = ST_OUT;
        end
      end
      ST_QRY: state_d = ST_OUT;
      ST_OUT: if (pop) state_d = ST_IDLE;
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_CLEAR;
      clr_q <= '0;
      wr_q <= '0;
      rd_q <= '0;
    end else begin
      state_q <= state_d;
      if (state_q == ST_CLEAR) begin
        clr_q <= clr_q + 1'b1;
      end
      if (we) begin
        wr_q <= wr_nxt;
      end
      if (state_q == ST_EVAL) begin
        rd_q <= rd_nxt;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    case (state_q)
      ST_IDLE: begin
        if (cmd_valid_i) begin
          cur_q <= cmd_i;
          found_q <= 1'b0;
          code_q <= 7'h00;
          rel_q <= 1'b0;
          down_q <= 1'b0;
          abort_q <= cmd_i.abort;
        end
      end
      ST_EVAL: begin
        if (!(cur_q.action == ACT_PRESS && rdata[7])) begin
          found_q <= 1'b1;
          code_q <= rdata[6:0];
          rel_q <= rdata[7];
        end
      end
      ST_QRY: down_q <= held_rdata;
      default: begin
      end
    endcase
  end
endmodule
`default_nettype wire

[rtl/ps2_set2_key_event_decoder.sv]
// Flow: the front decodes each item into a two-entry command buffer; the back sequencer
// steps IDLE, OUT for scan bytes; IDLE, QRY, OUT for queries; IDLE, READ, EVAL, OUT for
// pops (READ, OUT on an empty ring; a press pop repeats READ, EVAL per skipped release).
// The back takes a new item only in IDLE, once the previous result has been popped.
// Reset: asynchronous, active low; clears prefixes, modifiers and ring indices, then a
// pass over all 128 entries clears the held-key map before the first item is taken.
`default_nettype none
module ps2_set2_key_event_decoder import pkd_pkg::*; #(
  parameter int unsigned RingDepth = RingDepthDefault
) (
  input  wire logic       clk_i,
  input  wire logic       rst_ni,
  input  wire logic       push,
  output logic            full,
  input  wire logic [1:0] action_i,
  input  wire logic [7:0] scan_byte_i,
  input  wire logic [6:0] key_i,
  output logic            empty,
  input  wire logic       pop,
  output logic            found_o,
  output logic [6:0]      code_o,
  output logic            is_release_o,
  output logic            key_down_o,
  output logic            abort_request_o
);
  logic cmd_valid, cmd_ready;
  cmd_t cmd;

  pkd_front u_front (
    .clk_i, .rst_ni, .push, .full, .action_i, .scan_byte_i, .key_i,
    .cmd_valid_o(cmd_valid), .cmd_ready_i(cmd_ready), .cmd_o(cmd)
  );

  pkd_back #(.RingDepth(RingDepth)) u_back (
    .clk_i, .rst_ni, .cmd_valid_i(cmd_valid), .cmd_ready_o(cmd_ready), .cmd_i(cmd),
    .empty, .pop, .found_o, .code_o, .is_release_o, .key_down_o, .abort_request_o
  );
endmodule
`default_nettype wire

[rtl/pkd_checker.sv]
`default_nettype none
`include "ps2_set2_key_event_decoder_macros.svh"
module pkd_checker (
  input wire logic       clk_i,
  input wire logic       rst_ni,
  input wire logic       empty,
  input wire logic       pop,
  input wire logic       found_o,
  input wire logic [6:0] code_o,
  input wire logic       is_release_o,
  input wire logic       key_down_o,
  input wire logic       abort_request_o
);
  `PKD_ASSERT_IMPL(a_nf_code, clk_i, rst_ni, !empty && !found_o, code_o == 7'h00 && !is_release_o)
  `PKD_ASSERT_IMPL(a_found_nz, clk_i, rst_ni, !empty && found_o, code_o != 7'h00)
  `PKD_ASSERT_IMPL(a_excl, clk_i, rst_ni, !empty && found_o, !key_down_o && !abort_request_o)
  `PKD_ASSERT_NEXT(a_hold, clk_i, rst_ni, !empty && !pop, !empty && $stable(code_o))
endmodule

bind ps2_set2_key_event_decoder pkd_checker u_chk (
  .clk_i, .rst_ni, .empty, .pop, .found_o, .code_o, .is_release_o, .key_down_o,
  .abort_request_o
);
`default_nettype wire

[dv/ps2_key_event_checker.sv]
`timescale 1ns / 1ps
module ps2_key_event_checker import pkd_pkg::*; (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       push,
  input  logic       full,
  input  logic [1:0] action_i,
  input  logic [7:0] scan_byte_i,
  input  logic [6:0] key_i,
  input  logic       empty,
  input  logic       pop,
  input  logic       found_o,
  input  logic [6:0] code_o,
  input  logic       is_release_o,
  input  logic       key_down_o,
  input  logic       abort_request_o,
  output int         fail_count,
  output int         pending_count,
  output int         event_count,
  output int         abort_count
);

  typedef struct packed {
    logic       found;
    logic [6:0] code;
    logic       rel;
    logic       down;
    logic       abort;
  } key_result_t;

  localparam int unsigned RingSlots = RingDepthDefault - 1;

  logic [7:0] plain_rom [128] = '{
    8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00,
    8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h09, 8'h60, 8'h00,
    8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h71, 8'h31, 8'h00,
    8'h00, 8'h00, 8'h7a, 8'h73, 8'h61, 8'h77, 8'h32, 8'h00,
    8'h00, 8'h63, 8'h78, 8'h64, 8'h65, 8'h34, 8'h33, 8'h00,
    8'h00, 8'h20, 8'h76, 8'h66, 8'h74, 8'h72, 8'h35, 8'h00,
    8'h00, 8'h6e, 8'h62, 8'h68, 8'h67, 8'h79, 8'h36, 8'h00,
    8'h00, 8'h00, 8'h6d, 8'h6a, 8'h75, 8'h37, 8'h38, 8'h00,
    8'h00, 8'h2c, 8'h6b, 8'h69, 8'h6f, 8'h30, 8'h39, 8'h00,
    8'h00, 8'h2e, 8'h2f, 8'h6c, 8'h3b, 8'h70, 8'h2d, 8'h00,
    8'h00, 8'h00, 8'h27, 8'h00, 8'h5b, 8'h3d, 8'h00, 8'h00,
    8'h00, 8'h00, 8'h0a, 8'h5d, 8'h00, 8'h5c, 8'h00, 8'h00,
    8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h08, 8'h00,
    8'h00, 8'h31, 8'h00, 8'h34, 8'h37, 8'h00, 8'h00, 8'h00,
    8'h30, 8'h2e, 8'h32, 8'h35, 8'h36, 8'h38, 8'h1b, 8'h00,
    8'h00, 8'h2b, 8'h33, 8'h2d, 8'h2a, 8'h39, 8'h00, 8'h00
  };

  logic [7:0] shift_rom [128] = '{
    8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00,
    8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h09, 8'h7e, 8'h00,
    8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h51, 8'h21, 8'h00,
    8'h00, 8'h00, 8'h5a, 8'h53, 8'h41, 8'h57, 8'h40, 8'h00,
    8'h00, 8'h43, 8'h58, 8'h44, 8'h45, 8'h24, 8'h23, 8'h00,
    8'h00, 8'h20, 8'h56, 8'h46, 8'h54, 8'h52, 8'h25, 8'h00,
    8'h00, 8'h4e, 8'h42, 8'h48, 8'h47, 8'h59, 8'h5e, 8'h00,
    8'h00, 8'h00, 8'h4d, 8'h4a, 8'h55, 8'h26, 8'h2a, 8'h00,
    8'h00, 8'h3c, 8'h4b, 8'h49, 8'h4f, 8'h29, 8'h28, 8'h00,
    8'h00, 8'h3e, 8'h3f, 8'h4c, 8'h3a, 8'h50, 8'h5f, 8'h00,
    8'h00, 8'h00, 8'h22, 8'h00, 8'h7b, 8'h2b, 8'h00, 8'h00,
    8'h00, 8'h00, 8'h0a, 8'h7d, 8'h00, 8'h7c, 8'h00, 8'h00,
    8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h08, 8'h00,
    8'h00, 8'h31, 8'h00, 8'h34, 8'h37, 8'h00, 8'h00, 8'h00,
    8'h30, 8'h2e, 8'h32, 8'h35, 8'h36, 8'h38, 8'h1b, 8'h00,
    8'h00, 8'h2b, 8'h33, 8'h2d, 8'h2a, 8'h39, 8'h00, 8'h00
  };

  logic        shift_on, ctrl_on, break_seen, ext_seen;
  logic [7:0]  event_fifo [$];
  logic        held_map [128];
  key_result_t expected_results [$];

  function automatic key_result_t decode_item(input logic [1:0] act, input logic [7:0] sb,
                                              input logic [6:0] k);
    key_result_t r;
    logic        rel;
    logic [7:0]  c;
    logic [7:0]  ev;
    r = '0;
    c = 8'h00;
    case (action_e'(act))
      ACT_SCAN: begin
        if (sb == ScExt) begin
          ext_seen = 1'b1;
        end else if (sb == ScBreak) begin
          break_seen = 1'b1;
        end else begin
          rel = break_seen;
          break_seen = 1'b0;
          if (ext_seen) begin
            ext_seen = 1'b0;
            case (sb)
              ScUp:    c = {1'b0, CodeUp};
              ScDown:  c = {1'b0, CodeDown};
              ScLeft:  c = {1'b0, CodeLeft};
              ScRight: c = {1'b0, CodeRight};
              ScAlt:   c = {1'b0, CodeAlt};
              ScCtrl:  c = {1'b0, CodeCtrl};
              default: c = 8'h00;
            endcase
          end else if (sb == ScLsh || sb == ScRsh) begin
            shift_on = !rel;
            c = {1'b0, CodeShift};
          end else if (sb == ScCtrl) begin
            ctrl_on = !rel;
            c = {1'b0, CodeCtrl};
          end else if (sb == ScAlt) begin
            c = {1'b0, CodeAlt};
          end else if (!sb[7]) begin
            c = shift_on ? shift_rom[sb[6:0]] : plain_rom[sb[6:0]];
            if (ctrl_on && (c == "q" || c == "Q")) begin
              c = {1'b0, CodeCtrlQ};
              r.abort = !rel;
            end
          end
          if (c != 8'h00) begin
            held_map[c[6:0]] = !rel;
            if (event_fifo.size() < RingSlots) event_fifo.push_back({rel, c[6:0]});
          end
        end
      end
      ACT_POP: begin
        if (event_fifo.size() != 0) begin
          ev = event_fifo.pop_front();
          r.found = 1'b1;
          r.code = ev[6:0];
          r.rel = ev[7];
        end
      end
      ACT_PRESS: begin
        while (event_fifo.size() != 0 && !r.found) begin
          ev = event_fifo.pop_front();
          if (!ev[7]) begin
            r.found = 1'b1;
            r.code = ev[6:0];
          end
        end
      end
      default: r.down = held_map[k];
    endcase
    return r;
  endfunction

  initial begin
    shift_on = 1'b0;
    ctrl_on = 1'b0;
    break_seen = 1'b0;
    ext_seen = 1'b0;
    foreach (held_map[i]) held_map[i] = 1'b0;
    fail_count = 0;
    pending_count = 0;
    event_count = 0;
    abort_count = 0;
  end

  always @(posedge clk_i) begin
    key_result_t want;
    if (rst_ni) begin
      if (pop && !empty) begin
        if (expected_results.size() == 0) begin
          $error("result transfer with nothing expected");
          fail_count++;
        end else begin
          want = expected_results.pop_front();
          if (found_o !== want.found) begin
            $error("found: expected %0h actual %0h", want.found, found_o);
            fail_count++;
          end
          if (code_o !== want.code) begin
            $error("code: expected %0h actual %0h", want.code, code_o);
            fail_count++;
          end
          if (is_release_o !== want.rel) begin
            $error("is_release: expected %0h actual %0h", want.rel, is_release_o);
            fail_count++;
          end
          if (key_down_o !== want.down) begin
            $error("key_down: expected %0h actual %0h", want.down, key_down_o);
            fail_count++;
          end
          if (abort_request_o !== want.abort) begin
            $error("abort_request: expected %0h actual %0h", want.abort, abort_request_o);
            fail_count++;
          end
        end
      end
      if (push && !full) begin
        want = decode_item(action_i, scan_byte_i, key_i);
        if (want.found) event_count++;
        if (want.abort) abort_count++;
        expected_results.push_back(want);
      end
      pending_count = expected_results.size();
    end
  end

endmodule

[dv/tb.sv]
`timescale 1ns / 1ps
module tb;
  import pkd_pkg::*;

  logic       clk_i = 1'b0;
  logic       rst_ni = 1'b0;
  logic       push = 1'b0;
  logic       pop = 1'b0;
  logic [1:0] action_i = '0;
  logic [7:0] scan_byte_i = '0;
  logic [6:0] key_i = '0;
  logic       full, empty, found_o, is_release_o, key_down_o, abort_request_o;
  logic [6:0] code_o;
  int         fail_count, pending_count, event_count, abort_count;
  int         send_idle_pct = 24;
  int         recv_idle_pct = 60;
  int         recv_hold = 0;
  int         items_sent = 0;

  always #5 clk_i = ~clk_i;

  ps2_set2_key_event_decoder dut (.*);

  ps2_key_event_checker checker_i (.*);

  always @(negedge clk_i) begin
    if (recv_hold > 0) begin
      recv_hold <= recv_hold - 1;
      pop <= 1'b0;
    end else begin
      pop <= ($urandom_range(99) >= recv_idle_pct);
    end
  end

  task automatic send_item(input action_e act, input logic [7:0] sb, input logic [6:0] k);
    do begin
      @(negedge clk_i);
      if ($urandom_range(99) < send_idle_pct) begin
        push <= 1'b0;
      end else begin
        push <= 1'b1;
        action_i <= act;
        scan_byte_i <= sb;
        key_i <= k;
      end
      @(posedge clk_i);
    end while (!(push && !full));
    items_sent++;
  endtask

  task automatic send_scan(input logic [7:0] sb);
    send_item(ACT_SCAN, sb, 7'($urandom));
  endtask

  task automatic send_key_stroke();
    logic [7:0] sb;
    sb = ($urandom_range(9) == 0) ? 8'($urandom) : {1'b0, 7'($urandom)};
    case ($urandom_range(5))
      0: sb = ScLsh;
      1: sb = ScCtrl;
      2: sb = 8'h15;
      default: ;
    endcase
    if ($urandom_range(3) == 0) send_scan(ScExt);
    if ($urandom_range(9) < 4) send_scan(ScBreak);
    send_scan(sb);
  endtask

  task automatic run_random(input int n);
    repeat (n) begin
      case ($urandom_range(19))
        0, 1, 2:  send_item(ACT_POP, 8'($urandom), 7'($urandom));
        3, 4:     send_item(ACT_PRESS, 8'($urandom), 7'($urandom));
        5, 6, 7:  send_item(ACT_QUERY, 8'($urandom),
                            ($urandom_range(1) ? 7'($urandom_range(7)) : 7'($urandom)));
        8:        send_scan(8'($urandom));
        default:  send_key_stroke();
      endcase
    end
  endtask

  task automatic drain();
    @(negedge clk_i);
    push <= 1'b0;
    while (pending_count != 0) @(posedge clk_i);
    repeat (20) @(posedge clk_i);
  endtask

  initial begin
    repeat (4) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    send_item(ACT_POP, 8'hFF, 7'h7F);
    send_item(ACT_PRESS, 8'h00, 7'h00);
    send_scan(ScLsh);
    send_scan(8'h1C);
    send_scan(ScBreak);
    send_scan(ScRsh);
    send_scan(ScCtrl);
    send_scan(8'h15);
    send_scan(ScBreak);
    send_scan(8'h15);
    send_item(ACT_QUERY, 8'h00, CodeCtrl);
    send_scan(ScExt);
    send_scan(ScUp);
    send_scan(ScExt);
    send_scan(ScBreak);
    send_scan(ScCtrl);
    send_scan(ScExt);
    send_scan(8'h22);
    send_scan(8'h80);
    send_scan(8'hFF);
    send_scan(8'h00);
    send_scan(8'h7F);
    send_item(ACT_PRESS, 8'h00, 7'h00);
    send_item(ACT_QUERY, 8'h00, 7'h7F);
    send_item(ACT_POP, 8'h00, 7'h00);
    run_random(470);
    drain();

    send_idle_pct = 60;
    recv_idle_pct = 24;
    run_random(475);
    drain();

    send_idle_pct = 0;
    recv_idle_pct = 0;
    recv_hold = 400;
    run_random(475);
    drain();

    $display("Sent %0d items; %0d events popped, %0d abort pulses seen.",
             items_sent, event_count, abort_count);
    $display("Covered prefixes, modifiers, full ring, press pops and key queries.");
    if (fail_count == 0) begin
      $display("PASS ps2_set2_key_event_decoder");
    end else begin
      $display("FAIL ps2_set2_key_event_decoder");
    end
    $finish;
  end

  initial begin
    #20ms;
    $display("FAIL ps2_set2_key_event_decoder");
    $finish;
  end

endmodule
